@@ rtl/lsu_pkg.sv @@
package lsu_pkg;

	// field widths and default formats
	localparam int LSU_X_BITS        = 16;
	localparam int LSU_IN_FRAC_BITS  = 12;
	localparam int LSU_OUT_BITS      = 16;

	// series length and integer exponent table
	localparam int LSU_TERMS         = 16;
	localparam int LSU_EXPINT_DEPTH  = 32;
	localparam int LSU_K_BITS        = $clog2(LSU_EXPINT_DEPTH);

	// q0.31 constants: one and exp(-1) as the truncated series gives it
	localparam logic [31:0] LSU_Q31_ONE    = 32'h8000_0000;
	localparam logic [63:0] LSU_EXP_M1_Q31 = 64'd790015085;

	// dividend width of the final division
	localparam int LSU_DVD_BITS = 32 + LSU_OUT_BITS;

	// transfer to result: input stages, series, table and product, divider, fifo
	localparam int LSU_LATENCY = 2 + 2 * (LSU_TERMS - 1) + 1 + 2 + 1 + (LSU_OUT_BITS + 1) + 2;
	localparam int LSU_FIFO_DEPTH = 1 << $clog2(LSU_LATENCY + 4);

	// channel payloads
	typedef struct packed {
		logic signed [LSU_X_BITS-1:0] x_value;
		logic                         last_in;
	} lsu_in_t;

	typedef struct packed {
		logic [LSU_OUT_BITS-1:0] sigmoid_value;
		logic                    last_out;
	} lsu_out_t;

	// argument split into fraction and integer part
	typedef struct packed {
		logic [30:0]            t;
		logic [LSU_K_BITS-1:0]  k;
		logic                   big;
		logic                   positive;
		logic                   last;
	} lsu_arg_t;

	// exp of the fraction, with the integer part still attached
	typedef struct packed {
		logic [31:0]            frac;
		logic [LSU_K_BITS-1:0]  k;
		logic                   big;
		logic                   positive;
		logic                   last;
	} lsu_frac_t;

	// exp(-|x|) ready for the division
	typedef struct packed {
		logic [31:0] e;
		logic        positive;
		logic        last;
	} lsu_e_t;

	// exp(-k) in q0.31 by repeated rounded products, for table building only
	function automatic logic [31:0] lsu_exp_int_q31(input int k);
		logic [63:0] p;
		p = 64'(LSU_Q31_ONE);
		for (int i = 0; i < LSU_EXPINT_DEPTH; i++) begin
			if (i < k) begin
				p = (p * LSU_EXP_M1_Q31 + (64'd1 << 30)) >> 31;
			end
		end
		return p[31:0];
	endfunction

endpackage

@@ rtl/logistic_sigmoid_unit_top.sv @@
// channel   direction  payload                        transfer when
// sample    in         x_value (s16), last_in         sample_valid && !sample_stall
// result    out        sigmoid_value (u16), last_out  result_valid && !result_stall
//
// one sample per cycle while sample_stall is low; a result passes through the input stages,
// the series pipeline (two stages per term), the table and product stages and the divider
// (one quotient bit per stage), then the output fifo.
// reset clears valid bits, fifo pointers and the in-flight count; no clearing pass.
// sample_stall rises only when LSU_FIFO_DEPTH samples are in flight or unread;
// result_stall holds the output register and the fifo absorbs the pipeline.
module logistic_sigmoid_unit_top import lsu_pkg::*; #(
	parameter int IN_FRAC_BITS = LSU_IN_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	output logic     sample_stall,
	input  lsu_in_t  sample,
	output logic     result_valid,
	input  logic     result_stall,
	output lsu_out_t result
);

	localparam int          OCC_BITS  = $clog2(LSU_FIFO_DEPTH + 1);
	localparam logic [31:0] FRAC_MASK = (32'd1 << IN_FRAC_BITS) - 32'd1;

	logic [OCC_BITS-1:0] occ_q;
	logic                in_xfer;
	logic                out_xfer;

	// credit count: accepted samples whose results are not yet taken
	assign sample_stall = (occ_q == OCC_BITS'(LSU_FIFO_DEPTH));
	assign in_xfer      = sample_valid && !sample_stall;
	assign out_xfer     = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_BITS'(in_xfer) - OCC_BITS'(out_xfer);
		end
	end

	// magnitude and sign of the argument
	logic [15:0] raw;
	logic [15:0] mag;
	logic [15:0] m_s1;
	logic        positive_s1;
	logic        last_s1;
	logic        v_s1;

	assign raw = sample.x_value;
	assign mag = raw[15] ? (~raw + 16'd1) : raw;

	always_ff @(posedge clk) begin
		m_s1        <= mag;
		positive_s1 <= !raw[15] && (raw != '0);
		last_s1     <= sample.last_in;
	end

	// split into integer part and q0.31 fraction
	logic [15:0] kfull;
	lsu_arg_t    arg_s2;
	logic        v_s2;

	assign kfull = m_s1 >> IN_FRAC_BITS;

	always_ff @(posedge clk) begin
		arg_s2.t        <= 31'((32'(m_s1) & FRAC_MASK) << (31 - IN_FRAC_BITS));
		arg_s2.k        <= kfull[LSU_K_BITS-1:0];
		arg_s2.big      <= |kfull[15:LSU_K_BITS];
		arg_s2.positive <= positive_s1;
		arg_s2.last     <= last_s1;
	end

	// exp of the fraction
	logic      frac_valid;
	lsu_frac_t frac;

	lsu_exp_series u_series (
		.clk        (clk),
		.arst_n     (arst_n),
		.arg_valid  (v_s2),
		.arg        (arg_s2),
		.frac_valid (frac_valid),
		.frac       (frac)
	);

	// exp of the integer part from the table, aligned with the fraction
	logic [31:0] expint;
	logic [31:0] frac_s3;
	logic        positive_s3;
	logic        last_s3;
	logic        v_s3;

	lsu_exp_rom u_rom (
		.clk   (clk),
		.k     (frac.k),
		.big   (frac.big),
		.value (expint)
	);

	always_ff @(posedge clk) begin
		frac_s3     <= frac.frac;
		positive_s3 <= frac.positive;
		last_s3     <= frac.last;
	end

	// rounded product gives exp(-|x|)
	logic [63:0] eprod;
	lsu_e_t      e_s4;
	logic        v_s4;

	assign eprod = 64'(frac_s3) * 64'(expint);

	always_ff @(posedge clk) begin
		e_s4.e        <= 32'((eprod + (64'd1 << 30)) >> 31);
		e_s4.positive <= positive_s3;
		e_s4.last     <= last_s3;
	end

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= frac_valid;
			v_s4 <= v_s3;
		end
	end

	// final division and saturation
	logic     q_valid;
	lsu_out_t q;

	lsu_recip_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.e_valid (v_s4),
		.e_in    (e_s4),
		.q_valid (q_valid),
		.q       (q)
	);

	// results wait here until taken
	lsu_out_fifo #(
		.DEPTH (LSU_FIFO_DEPTH)
	) u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_valid     (q_valid),
		.wr_data      (q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ rtl/lsu_exp_rom.sv @@
module lsu_exp_rom import lsu_pkg::*; (
	input  logic                  clk,
	input  logic [LSU_K_BITS-1:0] k,
	input  logic                  big,
	output logic [31:0]           value
);

	logic [31:0] rom [LSU_EXPINT_DEPTH];
	logic [31:0] value_q;

	// table contents fixed at elaboration
	for (genvar g = 0; g < LSU_EXPINT_DEPTH; g++) begin : g_rom
		assign rom[g] = lsu_exp_int_q31(g);
	end

	// registered read, large integer parts give zero
	always_ff @(posedge clk) begin
		value_q <= big ? '0 : rom[k];
	end

	assign value = value_q;

endmodule

@@ rtl/lsu_exp_series.sv @@
module lsu_exp_series import lsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      arg_valid,
	input  lsu_arg_t  arg,
	output logic      frac_valid,
	output lsu_frac_t frac
);

	typedef struct packed {
		logic [30:0]            t;
		logic [30:0]            term;
		logic signed [33:0]     acc;
		logic [LSU_K_BITS-1:0]  k;
		logic                   big;
		logic                   positive;
		logic                   last;
	} ser_t;

	ser_t link   [1:LSU_TERMS];
	logic link_v [1:LSU_TERMS];

	// first term is t itself, sum starts at one
	assign link[1] = '{
		t:        arg.t,
		term:     arg.t,
		acc:      $signed({2'b00, LSU_Q31_ONE}),
		k:        arg.k,
		big:      arg.big,
		positive: arg.positive,
		last:     arg.last
	};
	assign link_v[1] = arg_valid;

	// one term per pair of stages: multiply by t, then divide by n
	for (genvar n = 2; n <= LSU_TERMS; n++) begin : g_term
		localparam int          SH    = 31 + $clog2(n);
		localparam logic [63:0] MAGIC = ((64'd1 << SH) + 64'(n) - 64'd1) / 64'(n);

		ser_t               mul_d;
		ser_t               mul_s1;
		ser_t               div_d;
		ser_t               div_s2;
		logic               mul_v_s1;
		logic               div_v_s2;
		logic [61:0]        prod;
		logic [62:0]        scaled;
		logic signed [33:0] acc_n;

		assign prod = 62'(link[n-1].term) * 62'(link[n-1].t);

		// previous term enters the sum with the sign of its index
		if ((n % 2) == 0) begin : g_sub
			assign acc_n = link[n-1].acc - $signed({3'b000, link[n-1].term});
		end else begin : g_add
			assign acc_n = link[n-1].acc + $signed({3'b000, link[n-1].term});
		end

		// product and running sum into the stage register
		always_comb begin
			mul_d      = link[n-1];
			mul_d.term = prod[61:31];
			mul_d.acc  = acc_n;
		end

		always_ff @(posedge clk) begin
			mul_s1 <= mul_d;
		end

		// exact floor division by n through a reciprocal
		assign scaled = 63'(mul_s1.term) * 63'(MAGIC[31:0]);

		always_comb begin
			div_d      = mul_s1;
			div_d.term = 31'(scaled >> SH);
		end

		always_ff @(posedge clk) begin
			div_s2 <= div_d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mul_v_s1 <= 1'b0;
				div_v_s2 <= 1'b0;
			end else begin
				mul_v_s1 <= link_v[n-1];
				div_v_s2 <= mul_v_s1;
			end
		end

		assign link[n]   = div_s2;
		assign link_v[n] = div_v_s2;
	end

	// last term joins the sum, negative totals clamp to zero
	logic signed [33:0] acc_last;
	lsu_frac_t          fin_s1;
	logic               fin_v_s1;

	if ((LSU_TERMS % 2) == 0) begin : g_last_add
		assign acc_last = link[LSU_TERMS].acc + $signed({3'b000, link[LSU_TERMS].term});
	end else begin : g_last_sub
		assign acc_last = link[LSU_TERMS].acc - $signed({3'b000, link[LSU_TERMS].term});
	end

	always_ff @(posedge clk) begin
		fin_s1.frac     <= acc_last[33] ? '0 : acc_last[31:0];
		fin_s1.k        <= link[LSU_TERMS].k;
		fin_s1.big      <= link[LSU_TERMS].big;
		fin_s1.positive <= link[LSU_TERMS].positive;
		fin_s1.last     <= link[LSU_TERMS].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s1 <= 1'b0;
		end else begin
			fin_v_s1 <= link_v[LSU_TERMS];
		end
	end

	assign frac       = fin_s1;
	assign frac_valid = fin_v_s1;

endmodule

@@ rtl/lsu_recip_div.sv @@
module lsu_recip_div import lsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     e_valid,
	input  lsu_e_t   e_in,
	output logic     q_valid,
	output lsu_out_t q
);

	localparam int QB = LSU_OUT_BITS + 1;
	localparam int DW = LSU_DVD_BITS;

	typedef struct packed {
		logic [32:0]   rem;
		logic [32:0]   den;
		logic [DW-1:0] dvd;
		logic [QB-1:0] quo;
		logic          last;
	} dstep_t;

	// denominator one plus e, numerator by sign, half the denominator for rounding
	logic [32:0]   den;
	logic [DW-1:0] num;
	logic [DW-1:0] dvd;
	dstep_t        prep_s1;
	logic          prep_v_s1;

	assign den = 33'(LSU_Q31_ONE) + 33'(e_in.e);
	assign num = e_in.positive ? (DW'(1) << (31 + LSU_OUT_BITS))
	                           : (DW'(e_in.e) << LSU_OUT_BITS);
	assign dvd = num + DW'(den >> 1);

	always_ff @(posedge clk) begin
		prep_s1.rem  <= 33'(dvd >> QB);
		prep_s1.den  <= den;
		prep_s1.dvd  <= dvd;
		prep_s1.quo  <= '0;
		prep_s1.last <= e_in.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_s1 <= 1'b0;
		end else begin
			prep_v_s1 <= e_valid;
		end
	end

	dstep_t link   [0:QB];
	logic   link_v [0:QB];

	assign link[0]   = prep_s1;
	assign link_v[0] = prep_v_s1;

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int BIT = QB - 1 - j;

		logic [33:0] r2;
		logic [33:0] diff;
		logic        ge;
		dstep_t      step_d;
		dstep_t      step_s1;
		logic        step_v_s1;

		assign r2   = {link[j].rem, link[j].dvd[BIT]};
		assign diff = r2 - {1'b0, link[j].den};
		assign ge   = (r2 >= {1'b0, link[j].den});

		// new remainder and quotient bit into the stage register
		always_comb begin
			step_d     = link[j];
			step_d.rem = ge ? diff[32:0] : r2[32:0];
			step_d.quo = {link[j].quo[QB-2:0], ge};
		end

		always_ff @(posedge clk) begin
			step_s1 <= step_d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_v_s1 <= 1'b0;
			end else begin
				step_v_s1 <= link_v[j];
			end
		end

		assign link[j+1]   = step_s1;
		assign link_v[j+1] = step_v_s1;
	end

	// a quotient of exactly one saturates
	assign q.sigmoid_value = link[QB].quo[QB-1] ? '1 : link[QB].quo[QB-2:0];
	assign q.last_out      = link[QB].last;
	assign q_valid         = link_v[QB];

endmodule

@@ rtl/lsu_out_fifo.sv @@
module lsu_out_fifo import lsu_pkg::*; #(
	parameter int DEPTH = LSU_FIFO_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	input  lsu_out_t wr_data,
	output logic     result_valid,
	input  logic     result_stall,
	output lsu_out_t result
);

	localparam int AW = $clog2(DEPTH);

	lsu_out_t      mem [DEPTH];
	logic [AW:0]   wr_ptr_q;
	logic [AW:0]   rd_ptr_q;
	lsu_out_t      rd_data_q;
	logic          rd_valid_q;
	logic          empty;
	logic          rd_en;

	assign empty = (wr_ptr_q == rd_ptr_q);

	// read when the output register is free or being drained
	assign rd_en = !empty && (!rd_valid_q || !result_stall);

	// storage and registered read port
	always_ff @(posedge clk) begin
		if (wr_valid) begin
			mem[wr_ptr_q[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_ptr_q[AW-1:0]];
		end
	end

	// pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q   <= rd_ptr_q + 1'b1;
				rd_valid_q <= 1'b1;
			end else if (!result_stall) begin
				rd_valid_q <= 1'b0;
			end
		end
	end

	assign result       = rd_data_q;
	assign result_valid = rd_valid_q;

endmodule
